// ===== src/plsf_pkg.sv =====
`timescale 1ns / 1ps

package plsf_pkg;

  // Default geometry of the stores
  localparam int DEF_WINDOWS             = 512;
  localparam int DEF_CHANNELS            = 16;
  localparam int DEF_SAMPLES_PER_CHANNEL = 32;
  localparam int DEF_TABLE_DEPTH         = 2048;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int WIN_W    = 9;
  localparam int SMP_W    = 16;
  localparam int ADDR_W   = 18;
  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_PED   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TABLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WINDOW     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WINDOW   = 1'd1;

  // Frame bytes
  localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'hAA;
  localparam logic [BYTE_W-1:0] TRL_BYTE0 = 8'h33;
  localparam logic [BYTE_W-1:0] TRL_BYTE1 = 8'hCC;
  localparam logic [BYTE_W-1:0] ERR_BYTE  = 8'h00;

  // Saturation limit on the pedestal-corrected sample
  localparam logic [SMP_W-1:0] SAT_LIMIT = 16'd2047;

  // Up to four bytes handed to the serializer as one batch
  localparam int BATCH_MAX = 4;
  localparam int BCNT_W    = 3;

  typedef struct packed {
    logic [BATCH_MAX-1:0][BYTE_W-1:0] bytes;
    logic [BCNT_W-1:0]                num;
    logic                             fend;
    logic                             err;
  } batch_t;

endpackage

// ===== src/plsf_ram.sv =====
`timescale 1ns / 1ps

module plsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/plsf_serializer.sv =====
`timescale 1ns / 1ps

module plsf_serializer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  plsf_pkg::batch_t                 batch,
  output logic                             free,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [plsf_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_run_last,
  output logic                             out_frame_end,
  output logic                             out_id_error
);

  logic [plsf_pkg::BATCH_MAX-1:0][plsf_pkg::BYTE_W-1:0] bytes_r, bytes_nxt;
  logic [1:0]                     pos_r, pos_nxt;
  logic [plsf_pkg::BCNT_W-1:0]    rem_r, rem_nxt;
  logic                           fend_r, fend_nxt;
  logic                           err_r, err_nxt;
  logic                           take;

  assign out_valid     = (rem_r != '0);
  assign take          = out_valid && !out_stall;
  assign free          = (rem_r == '0) || ((rem_r == plsf_pkg::BCNT_W'(1)) && !out_stall);
  assign out_byte      = bytes_r[pos_r];
  assign out_run_last  = (rem_r == plsf_pkg::BCNT_W'(1));
  assign out_frame_end = out_run_last && fend_r;
  assign out_id_error  = err_r;

  always_comb begin
    bytes_nxt = bytes_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    fend_nxt  = fend_r;
    err_nxt   = err_r;
    if (load) begin
      bytes_nxt = batch.bytes;
      pos_nxt   = 2'd0;
      rem_nxt   = batch.num;
      fend_nxt  = batch.fend;
      err_nxt   = batch.err;
    end else if (take) begin
      pos_nxt = pos_r + 2'd1;
      rem_nxt = rem_r - plsf_pkg::BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      rem_r  <= '0;
      fend_r <= 1'b0;
      err_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      rem_r  <= rem_nxt;
      fend_r <= fend_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

// ===== src/pedestal_lut_sample_framer_core.sv =====
`timescale 1ns / 1ps

// Pedestal-corrected sample framer. Input transactions load the pedestal
// store and the transfer table, open a frame (window start) or carry one raw
// sample. A window start whose id matches the expected id sends 55 AA and the
// 16-bit frame count (low byte first); a mismatch sends one byte with
// id_error set and halts the block until reset. Each sample of an open frame
// becomes (sample + offset - pedestal) mod 2^16, clipped to 2047, looked up in
// the table and sent as two bytes, low first; the last sample of a frame also
// sends 33 CC with frame_end. The input takes one transaction per cycle while
// in_stall is low; the byte-wide result channel sets the sustained rate: a
// sample sends two bytes, a window start or frame-closing sample four, an
// error one, and loads none. An accepted transaction passes the pedestal read,
// the table read and the serializer before its first result byte leaves. Both
// stores are plain RAMs with no clearing pass: they hold garbage until loaded.
module pedestal_lut_sample_framer_core #(
  parameter int WINDOWS             = plsf_pkg::DEF_WINDOWS,
  parameter int CHANNELS            = plsf_pkg::DEF_CHANNELS,
  parameter int SAMPLES_PER_CHANNEL = plsf_pkg::DEF_SAMPLES_PER_CHANNEL,
  parameter int TABLE_DEPTH         = plsf_pkg::DEF_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [plsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plsf_pkg::SMP_W-1:0]        cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [plsf_pkg::CMD_W-1:0]        in_command,
  input  logic [plsf_pkg::WIN_W-1:0]        in_window_id,
  input  logic [plsf_pkg::SMP_W-1:0]        in_sample_value,
  input  logic [plsf_pkg::ADDR_W-1:0]       in_table_address,
  input  logic [plsf_pkg::WORD_W-1:0]       in_table_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [plsf_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_run_last,
  output logic                              out_frame_end,
  output logic                              out_id_error
);

  localparam int FRAME_SAMPLES = CHANNELS * SAMPLES_PER_CHANNEL;
  localparam int PED_DEPTH     = WINDOWS * FRAME_SAMPLES;
  localparam int PAW           = (PED_DEPTH > 1) ? $clog2(PED_DEPTH) : 1;
  localparam int TAW           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SPW           = $clog2(FRAME_SAMPLES + 1);

  // Kind of transaction travelling down the pipe
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_ERR = 2'd1;
  localparam logic [1:0] KIND_SMP = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration and frame state
  // ---------------------------------------------------------------------------
  logic [plsf_pkg::SMP_W-1:0] offset_r, offset_nxt;
  logic [plsf_pkg::WIN_W-1:0] first_win_r, first_win_nxt;
  logic [plsf_pkg::WIN_W-1:0] exp_win_r, exp_win_nxt;
  logic [plsf_pkg::WIN_W-1:0] cur_win_r, cur_win_nxt;
  logic [SPW-1:0]             spos_r, spos_nxt;
  logic [plsf_pkg::CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic                       halted_r, halted_nxt;
  logic                       open_r, open_nxt;

  // Pipeline stage 1: pedestal read in flight
  logic                       s1_v_r, s1_v_nxt;
  logic [1:0]                 s1_kind_r, s1_kind_nxt;
  logic [plsf_pkg::SMP_W-1:0] s1_sval_r, s1_sval_nxt;
  logic                       s1_pzero_r, s1_pzero_nxt;
  logic                       s1_last_r, s1_last_nxt;
  logic [plsf_pkg::CNT_W-1:0] s1_cnt_r, s1_cnt_nxt;

  // Pipeline stage 2: table read in flight
  logic                       s2_v_r;
  logic [1:0]                 s2_kind_r;
  logic                       s2_tzero_r;
  logic                       s2_last_r;
  logic [plsf_pkg::CNT_W-1:0] s2_cnt_r;

  logic in_accept;
  logic adv_s1, adv_s2;
  logic ser_free, ser_load;
  plsf_pkg::batch_t batch;

  // RAM hookup
  logic                        ped_we, ped_re;
  logic [PAW-1:0]              ped_waddr, ped_raddr;
  logic [plsf_pkg::WORD_W-1:0] ped_rdata;
  logic                        tab_we, tab_re;
  logic [TAW-1:0]              tab_waddr, tab_raddr;
  logic [plsf_pkg::WORD_W-1:0] tab_rdata;

  logic [31:0]                 ped_addr_full;
  logic [31:0]                 in_addr_ext;
  logic [31:0]                 tab_addr_full;
  logic                        ped_zero;
  logic                        smp_last;

  logic [plsf_pkg::WORD_W-1:0] ped_word;
  logic [plsf_pkg::SMP_W-1:0]  diff;
  logic [plsf_pkg::SMP_W-1:0]  sat;
  logic                        tab_zero;
  logic [plsf_pkg::WORD_W-1:0] word;

  // ---------------------------------------------------------------------------
  // Flow control: a transaction enters whenever stage 1 can move on
  // ---------------------------------------------------------------------------
  assign ser_load  = s2_v_r && ser_free;
  assign adv_s2    = !s2_v_r || ser_free;
  assign adv_s1    = !s1_v_r || adv_s2;
  assign in_stall  = !adv_s1;
  assign in_accept = in_valid && adv_s1;

  // Pedestal address of the next sample in the open frame
  assign ped_addr_full = (32'(cur_win_r) * 32'(FRAME_SAMPLES)) + 32'(spos_r);
  assign ped_zero      = (32'(cur_win_r) >= 32'(WINDOWS));
  assign smp_last      = (spos_r == SPW'(FRAME_SAMPLES - 1));
  assign in_addr_ext   = 32'(in_table_address);

  // ---------------------------------------------------------------------------
  // Command decode at acceptance
  // ---------------------------------------------------------------------------
  always_comb begin
    offset_nxt    = offset_r;
    first_win_nxt = first_win_r;
    exp_win_nxt   = exp_win_r;
    cur_win_nxt   = cur_win_r;
    spos_nxt      = spos_r;
    fcnt_nxt      = fcnt_r;
    halted_nxt    = halted_r;
    open_nxt      = open_r;

    s1_v_nxt      = 1'b0;
    s1_kind_nxt   = KIND_HDR;
    s1_sval_nxt   = in_sample_value;
    s1_pzero_nxt  = ped_zero;
    s1_last_nxt   = smp_last;
    s1_cnt_nxt    = fcnt_r;

    ped_we    = 1'b0;
    ped_re    = 1'b0;
    tab_we    = 1'b0;
    ped_waddr = in_addr_ext[PAW-1:0];
    tab_waddr = in_addr_ext[TAW-1:0];
    ped_raddr = ped_addr_full[PAW-1:0];

    // Configuration is to be written only while idle; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        plsf_pkg::CFG_DIGITAL_OFFSET: offset_nxt = cfg_wdata;
        plsf_pkg::CFG_FIRST_WINDOW: begin
          first_win_nxt = cfg_wdata[plsf_pkg::WIN_W-1:0];
          exp_win_nxt   = cfg_wdata[plsf_pkg::WIN_W-1:0];
        end
      endcase
    end

    if (in_accept && !halted_r) begin
      unique case (in_command)
        plsf_pkg::CMD_LOAD_PED: begin
          ped_we = (in_addr_ext < 32'(PED_DEPTH));
        end
        plsf_pkg::CMD_LOAD_TABLE: begin
          tab_we = (in_addr_ext < 32'(TABLE_DEPTH));
        end
        plsf_pkg::CMD_WINDOW: begin
          open_nxt = 1'b0;
          s1_v_nxt = 1'b1;
          if (in_window_id != exp_win_r) begin
            halted_nxt  = 1'b1;
            s1_kind_nxt = KIND_ERR;
          end else begin
            s1_kind_nxt = KIND_HDR;
            cur_win_nxt = in_window_id;
            spos_nxt    = '0;
            open_nxt    = 1'b1;
            fcnt_nxt    = fcnt_r + plsf_pkg::CNT_W'(1);
            exp_win_nxt = exp_win_r + plsf_pkg::WIN_W'(1);
          end
        end
        plsf_pkg::CMD_SAMPLE: begin
          if (open_r) begin
            s1_v_nxt    = 1'b1;
            s1_kind_nxt = KIND_SMP;
            ped_re      = 1'b1;
            if (smp_last) begin
              open_nxt = 1'b0;
              spos_nxt = '0;
            end else begin
              spos_nxt = spos_r + SPW'(1);
            end
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: pedestal subtraction, clipping, table read
  // ---------------------------------------------------------------------------
  assign ped_word      = s1_pzero_r ? '0 : ped_rdata;
  assign diff          = s1_sval_r + offset_r - ped_word;
  assign sat           = (diff > plsf_pkg::SAT_LIMIT) ? plsf_pkg::SAT_LIMIT : diff;
  assign tab_addr_full = 32'(sat);
  assign tab_zero      = (tab_addr_full >= 32'(TABLE_DEPTH));
  assign tab_raddr     = tab_addr_full[TAW-1:0];
  assign tab_re        = adv_s2 && s1_v_r && (s1_kind_r == KIND_SMP);

  // ---------------------------------------------------------------------------
  // Stage 2 -> serializer: build the byte batch
  // ---------------------------------------------------------------------------
  assign word = s2_tzero_r ? '0 : tab_rdata;

  always_comb begin
    batch.bytes = '0;
    batch.num   = plsf_pkg::BCNT_W'(1);
    batch.fend  = 1'b0;
    batch.err   = 1'b0;
    unique case (s2_kind_r)
      KIND_HDR: begin
        batch.bytes[0] = plsf_pkg::HDR_BYTE0;
        batch.bytes[1] = plsf_pkg::HDR_BYTE1;
        batch.bytes[2] = s2_cnt_r[7:0];
        batch.bytes[3] = s2_cnt_r[15:8];
        batch.num      = plsf_pkg::BCNT_W'(4);
      end
      KIND_ERR: begin
        batch.bytes[0] = plsf_pkg::ERR_BYTE;
        batch.err      = 1'b1;
      end
      KIND_SMP: begin
        batch.bytes[0] = word[7:0];
        batch.bytes[1] = word[15:8];
        batch.bytes[2] = plsf_pkg::TRL_BYTE0;
        batch.bytes[3] = plsf_pkg::TRL_BYTE1;
        batch.num      = s2_last_r ? plsf_pkg::BCNT_W'(4) : plsf_pkg::BCNT_W'(2);
        batch.fend     = s2_last_r;
      end
      default: begin
        batch.num = plsf_pkg::BCNT_W'(1);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      first_win_r <= '0;
      exp_win_r   <= '0;
      cur_win_r   <= '0;
      spos_r      <= '0;
      fcnt_r      <= '0;
      halted_r    <= 1'b0;
      open_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      first_win_r <= first_win_nxt;
      exp_win_r   <= exp_win_nxt;
      cur_win_r   <= cur_win_nxt;
      spos_r      <= spos_nxt;
      fcnt_r      <= fcnt_nxt;
      halted_r    <= halted_nxt;
      open_r      <= open_nxt;
      if (adv_s1) begin
        s1_v_r <= in_accept ? s1_v_nxt : 1'b0;
      end
      if (adv_s2) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Pipeline payload, no reset
  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_sval_r  <= s1_sval_nxt;
      s1_pzero_r <= s1_pzero_nxt;
      s1_last_r  <= s1_last_nxt;
      s1_cnt_r   <= s1_cnt_nxt;
    end
    if (adv_s2) begin
      s2_kind_r  <= s1_kind_r;
      s2_tzero_r <= tab_zero;
      s2_last_r  <= s1_last_r;
      s2_cnt_r   <= s1_cnt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  plsf_ram #(
    .WIDTH (plsf_pkg::WORD_W),
    .DEPTH (PED_DEPTH)
  ) u_ped_ram (
    .clk   (clk),
    .we    (ped_we),
    .waddr (ped_waddr),
    .wdata (in_table_value),
    .re    (ped_re),
    .raddr (ped_raddr),
    .rdata (ped_rdata)
  );

  plsf_ram #(
    .WIDTH (plsf_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (in_table_value),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // ---------------------------------------------------------------------------
  // Byte serializer and result register
  // ---------------------------------------------------------------------------
  plsf_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (ser_load),
    .batch         (batch),
    .free          (ser_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end),
    .out_id_error  (out_id_error)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Checks the pedestal framer end to end. Inside a frame, each sample is
// preceded where needed by loads of the pedestal word and the table word it
// will read, so no sample ever touches an unwritten entry. A small scoreboard
// mirrors the block's state and predicts the byte stream, and every byte the
// block hands out is compared against that prediction.
module tb;

  localparam int FRAME_LEN = plsf_pkg::DEF_CHANNELS * plsf_pkg::DEF_SAMPLES_PER_CHANNEL;
  localparam int PED_DEPTH = plsf_pkg::DEF_WINDOWS * FRAME_LEN;

  // One byte of the outgoing stream with its flags
  typedef struct packed {
    logic [plsf_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic                        fend;
    logic                        err;
  } stream_byte_t;

  // Mirrors the framer state and keeps the bytes it still owes us
  class frame_scoreboard;
    logic [plsf_pkg::WORD_W-1:0] ped_word [int];   // exists() == written
    logic [plsf_pkg::WORD_W-1:0] lut [int];        // exists() == written
    logic [plsf_pkg::SMP_W-1:0]  offset;
    logic [plsf_pkg::WIN_W-1:0]  expected_win;
    logic [plsf_pkg::WIN_W-1:0]  current_win;
    logic [plsf_pkg::CNT_W-1:0]  frame_count;
    int                          pos;
    bit                          open;
    bit                          halted;
    stream_byte_t                expected_bytes [$];
    int                          errors, n_in, n_out, n_opened, n_id_errors;

    function new();
      offset       = '0;
      expected_win = '0;
      current_win  = '0;
      frame_count  = '0;
      pos          = 0;
      open         = 0;
      halted       = 0;
    endfunction

    function void push(logic [plsf_pkg::BYTE_W-1:0] d, bit l, bit f, bit e);
      expected_bytes.push_back({d, l, f, e});
    endfunction

    function void note_config(logic [plsf_pkg::CFG_IDX_W-1:0] idx,
                              logic [plsf_pkg::SMP_W-1:0] data);
      if (idx == plsf_pkg::CFG_DIGITAL_OFFSET) offset = data;
      else expected_win = data[plsf_pkg::WIN_W-1:0];  // first_window also reloads the expectation
    endfunction

    // Accepted input transaction: update state, queue the bytes it causes
    function void absorb_item(logic [plsf_pkg::CMD_W-1:0] cmd, logic [plsf_pkg::WIN_W-1:0] wid,
                              logic [plsf_pkg::SMP_W-1:0] sval,
                              logic [plsf_pkg::ADDR_W-1:0] addr,
                              logic [plsf_pkg::WORD_W-1:0] tval);
      logic [plsf_pkg::SMP_W-1:0]  v;
      logic [plsf_pkg::WORD_W-1:0] ped;
      logic [plsf_pkg::WORD_W-1:0] word;
      int                          idx;
      n_in++;
      if (halted) return;
      case (cmd)
        plsf_pkg::CMD_LOAD_PED: ped_word[int'(addr)] = tval;
        plsf_pkg::CMD_LOAD_TABLE:
          if (int'(addr) < plsf_pkg::DEF_TABLE_DEPTH) lut[int'(addr)] = tval;
        plsf_pkg::CMD_WINDOW: begin
          open = 0;
          if (wid != expected_win) begin
            halted = 1;
            n_id_errors++;
            push(plsf_pkg::ERR_BYTE, 1'b1, 1'b0, 1'b1);
          end else begin
            current_win = wid;
            pos         = 0;
            open        = 1;
            n_opened++;
            push(plsf_pkg::HDR_BYTE0, 1'b0, 1'b0, 1'b0);
            push(plsf_pkg::HDR_BYTE1, 1'b0, 1'b0, 1'b0);
            push(frame_count[7:0], 1'b0, 1'b0, 1'b0);
            push(frame_count[15:8], 1'b1, 1'b0, 1'b0);
            frame_count++;
            expected_win++;
          end
        end
        plsf_pkg::CMD_SAMPLE: if (open) begin
          idx  = int'(current_win) * FRAME_LEN + pos;
          ped  = ped_word.exists(idx) ? ped_word[idx] : '0;
          v    = sval + offset - ped;             // wraps mod 2^16
          if (v > plsf_pkg::SAT_LIMIT) v = plsf_pkg::SAT_LIMIT;
          word = lut.exists(int'(v)) ? lut[int'(v)] : '0;
          pos++;
          push(word[7:0], 1'b0, 1'b0, 1'b0);
          if (pos < FRAME_LEN) begin
            push(word[15:8], 1'b1, 1'b0, 1'b0);
          end else begin
            push(word[15:8], 1'b0, 1'b0, 1'b0);
            push(plsf_pkg::TRL_BYTE0, 1'b0, 1'b0, 1'b0);
            push(plsf_pkg::TRL_BYTE1, 1'b1, 1'b1, 1'b0);
            open = 0;
            pos  = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [plsf_pkg::BYTE_W-1:0] data, logic last, logic fend,
                             logic err);
      stream_byte_t want;
      n_out++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h run_last %b frame_end %b id_error %b",
               data, last, fend, err);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("run_last: expected %b, got %b", want.last, last);
        errors++;
      end
      if (fend !== want.fend) begin
        $error("frame_end: expected %b, got %b", want.fend, fend);
        errors++;
      end
      if (err !== want.err) begin
        $error("id_error: expected %b, got %b", want.err, err);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n            = 1'b0;
  logic                           cfg_we           = 1'b0;
  logic [plsf_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic [plsf_pkg::SMP_W-1:0]     cfg_wdata        = '0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [plsf_pkg::CMD_W-1:0]     in_command       = '0;
  logic [plsf_pkg::WIN_W-1:0]     in_window_id     = '0;
  logic [plsf_pkg::SMP_W-1:0]     in_sample_value  = '0;
  logic [plsf_pkg::ADDR_W-1:0]    in_table_address = '0;
  logic [plsf_pkg::WORD_W-1:0]    in_table_value   = '0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic [plsf_pkg::BYTE_W-1:0]    out_byte;
  logic                           out_run_last;
  logic                           out_frame_end;
  logic                           out_id_error;

  frame_scoreboard sb = new();

  bit calm;            // set: neither side idles at random
  bit want_backlog;    // set by stimulus: ask the receiver for one long hold-off
  bit backlog_done;
  int hold_left;

  pedestal_lut_sample_framer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_window_id     (in_window_id),
    .in_sample_value  (in_sample_value),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end),
    .out_id_error     (out_id_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block wedges
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: sample the handshake with pre-edge values, then pick the
  // next stall. One long hold-off, on request, lets the block back up.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_byte(out_byte, out_run_last, out_frame_end, out_id_error);
    if (want_backlog && !backlog_done) begin
      hold_left    = 250;
      backlog_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 27);
    end
  end

  // Table and pedestal words: mostly random, sometimes the extremes
  function automatic logic [plsf_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return plsf_pkg::WORD_W'($urandom);
    endcase
  endfunction

  // Pedestal address of the next sample in the open frame
  function automatic int cur_idx();
    return int'(sb.current_win) * FRAME_LEN + sb.pos;
  endfunction

  // Offer one input transaction, with random idle cycles ahead of it,
  // and hand it to the scoreboard at the edge where it is taken.
  task automatic send(input logic [plsf_pkg::CMD_W-1:0] cmd,
                      input logic [plsf_pkg::WIN_W-1:0] wid,
                      input logic [plsf_pkg::SMP_W-1:0] sval,
                      input logic [plsf_pkg::ADDR_W-1:0] addr,
                      input logic [plsf_pkg::WORD_W-1:0] tval);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_window_id     <= wid;
    in_sample_value  <= sval;
    in_table_address <= addr;
    in_table_value   <= tval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_item(cmd, wid, sval, addr, tval);
  endtask

  task automatic open_window();
    send(plsf_pkg::CMD_WINDOW, sb.expected_win, plsf_pkg::SMP_W'($urandom),
         plsf_pkg::ADDR_W'($urandom), plsf_pkg::WORD_W'($urandom));
  endtask

  task automatic load_pedestal();
    if (!sb.ped_word.exists(cur_idx()))
      send(plsf_pkg::CMD_LOAD_PED, plsf_pkg::WIN_W'($urandom), plsf_pkg::SMP_W'($urandom),
           plsf_pkg::ADDR_W'(cur_idx()), pick_word());
  endtask

  // A sample with the given raw value; inside a frame its pedestal word and
  // the table word it will hit are loaded first when missing.
  task automatic send_value(input logic [plsf_pkg::SMP_W-1:0] sval);
    logic [plsf_pkg::SMP_W-1:0] v;
    if (sb.open) begin
      load_pedestal();
      v = sval + sb.offset - sb.ped_word[cur_idx()];
      if (v > plsf_pkg::SAT_LIMIT) v = plsf_pkg::SAT_LIMIT;
      if (!sb.lut.exists(int'(v)))
        send(plsf_pkg::CMD_LOAD_TABLE, plsf_pkg::WIN_W'($urandom), plsf_pkg::SMP_W'($urandom),
             plsf_pkg::ADDR_W'(v), pick_word());
    end
    send(plsf_pkg::CMD_SAMPLE, plsf_pkg::WIN_W'($urandom), sval,
         plsf_pkg::ADDR_W'($urandom), plsf_pkg::WORD_W'($urandom));
  endtask

  // Aimed samples land the corrected value in 0..2100, around the clip point;
  // plain random ones almost always clip.
  task automatic send_sample(input bit aimed);
    logic [plsf_pkg::SMP_W-1:0] sval;
    sval = plsf_pkg::SMP_W'($urandom);
    if (sb.open && aimed) begin
      load_pedestal();
      sval = sb.ped_word[cur_idx()] - sb.offset + plsf_pkg::SMP_W'($urandom_range(0, 2100));
    end
    send_value(sval);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_reg(input logic [plsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [plsf_pkg::SMP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.note_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every owed byte, then let the pipe (3 deep) empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly short frames with random content; each new window start
  // drops the frame before it. The rest is table and pedestal noise.
  task automatic random_traffic(input int quota);
    int stop_at;
    int n;
    stop_at = sb.n_in + quota;
    while (sb.n_in < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: send(plsf_pkg::CMD_LOAD_TABLE, plsf_pkg::WIN_W'($urandom),
                   plsf_pkg::SMP_W'($urandom),
                   ($urandom_range(0, 3) == 0) ? plsf_pkg::ADDR_W'($urandom) :
                     plsf_pkg::ADDR_W'($urandom_range(0, plsf_pkg::DEF_TABLE_DEPTH - 1)),
                   pick_word());
        2: send(plsf_pkg::CMD_LOAD_PED, plsf_pkg::WIN_W'($urandom), plsf_pkg::SMP_W'($urandom),
                plsf_pkg::ADDR_W'($urandom), pick_word());
        default: begin
          open_window();
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
          repeat (n) send_sample($urandom_range(0, 3) != 0);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, 16'h0000);
    write_reg(plsf_pkg::CFG_FIRST_WINDOW, 16'h0000);

    // Directed part, offset 0
    send(plsf_pkg::CMD_SAMPLE, 9'h1FF, 16'hFFFF, 18'h3FFFF, 16'hFFFF);  // no frame open: dropped
    send(plsf_pkg::CMD_LOAD_TABLE, '0, '0,
         plsf_pkg::ADDR_W'(plsf_pkg::DEF_TABLE_DEPTH), 16'hDEAD);    // one past the table
    send(plsf_pkg::CMD_LOAD_TABLE, '1, '1, 18'h3FFFF, 16'hBEEF);       // top address: dropped
    send(plsf_pkg::CMD_LOAD_TABLE, '0, '0, 18'd0, pick_word());
    send(plsf_pkg::CMD_LOAD_TABLE, '0, '0, 18'd1, pick_word());
    send(plsf_pkg::CMD_LOAD_TABLE, '0, '0, plsf_pkg::ADDR_W'(plsf_pkg::SAT_LIMIT), pick_word());
    send(plsf_pkg::CMD_LOAD_PED, '0, '0, 18'd0, 16'h0000);
    send(plsf_pkg::CMD_LOAD_PED, '0, '0, 18'd1, 16'hFFFF);
    send(plsf_pkg::CMD_LOAD_PED, '0, '0, 18'd2, 16'h0100);
    send(plsf_pkg::CMD_LOAD_PED, '0, '0, 18'd3, 16'h0000);
    send(plsf_pkg::CMD_LOAD_PED, '0, '0, plsf_pkg::ADDR_W'(PED_DEPTH - 1), 16'h5A5A);
    send(plsf_pkg::CMD_WINDOW, 9'd0, '0, '0, '0);                      // header, count 0
    send(plsf_pkg::CMD_SAMPLE, '0, 16'h0000, '0, '0);                  // corrected value 0
    send(plsf_pkg::CMD_SAMPLE, '0, 16'h0000, '0, '0);                  // 0 - FFFF wraps to 1
    send(plsf_pkg::CMD_SAMPLE, '0, 16'h08FF, '0, '0);                  // exactly 2047
    send(plsf_pkg::CMD_SAMPLE, '0, 16'h0800, '0, '0);                  // 2048, clipped
    open_window();                                                     // restart inside open frame
    repeat (3) send_sample(1);
    send_value(16'hFFFF);
    drain();

    // Partial frame at the top window, offset at its maximum, no idling at all
    calm = 1;
    write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, 16'hFFFF);
    write_reg(plsf_pkg::CFG_FIRST_WINDOW, 16'h01FF);
    open_window();
    repeat (24) send_sample(1);
    drain();
    calm = 0;

    // Random phases over several register settings; phase 0 keeps the
    // expected window that wrapped from 511 to 0
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, plsf_pkg::SMP_W'($urandom));
        1: begin
          write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, 16'h0000);
          write_reg(plsf_pkg::CFG_FIRST_WINDOW, plsf_pkg::SMP_W'($urandom));
        end
        2: begin
          write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, plsf_pkg::SMP_W'($urandom));
          write_reg(plsf_pkg::CFG_FIRST_WINDOW, 16'h01FF);
        end
        default: begin
          write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, 16'hFFFF);
          write_reg(plsf_pkg::CFG_FIRST_WINDOW, 16'h0000);
        end
      endcase
      random_traffic(65);
      drain();
    end

    // Long frame while the receiver holds off long enough to back the
    // block up into its input
    write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, plsf_pkg::SMP_W'($urandom));
    want_backlog = 1;
    open_window();
    repeat (30) send_sample($urandom_range(0, 3) != 0);
    drain();

    // Wrong window id: one error byte, then everything is dropped for good
    send(plsf_pkg::CMD_WINDOW, plsf_pkg::WIN_W'(sb.expected_win + $urandom_range(1, 511)),
         plsf_pkg::SMP_W'($urandom), plsf_pkg::ADDR_W'($urandom), plsf_pkg::WORD_W'($urandom));
    repeat (6) send(plsf_pkg::CMD_W'($urandom), plsf_pkg::WIN_W'($urandom),
                    plsf_pkg::SMP_W'($urandom), plsf_pkg::ADDR_W'($urandom),
                    plsf_pkg::WORD_W'($urandom));
    drain();
    write_reg(plsf_pkg::CFG_FIRST_WINDOW, plsf_pkg::SMP_W'($urandom));
    write_reg(plsf_pkg::CFG_DIGITAL_OFFSET, plsf_pkg::SMP_W'($urandom));
    open_window();
    send_sample(1);
    drain();

    $display("covered %0d input transactions, %0d result bytes, %0d frames opened",
             sb.n_in, sb.n_out, sb.n_opened);
    $display("offsets 0, FFFF and random; first window 0, 511 and random; %0d id error(s)",
             sb.n_id_errors);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/plsf_pkg.sv
src/plsf_ram.sv
src/plsf_serializer.sv
src/pedestal_lut_sample_framer_core.sv
bench/tb.sv
